FILE: rtl/cnls_pkg.sv
// Shared types and constants of the C numeric literal scanner.
package cnls_pkg;

  localparam int unsigned PhaseW  = 4;
  localparam int unsigned StatusW = 2;
  localparam int unsigned QueueDepth = 2;

  // Scan phase codes.
  localparam logic [PhaseW-1:0] PhIdle     = 4'd0;
  localparam logic [PhaseW-1:0] PhInt      = 4'd1;
  localparam logic [PhaseW-1:0] PhFrac     = 4'd2;
  localparam logic [PhaseW-1:0] PhExpSign  = 4'd3;
  localparam logic [PhaseW-1:0] PhExpFirst = 4'd4;
  localparam logic [PhaseW-1:0] PhExpDig   = 4'd5;
  localparam logic [PhaseW-1:0] PhU        = 4'd6;
  localparam logic [PhaseW-1:0] PhUl       = 4'd7;
  localparam logic [PhaseW-1:0] PhL        = 4'd8;
  localparam logic [PhaseW-1:0] PhLl       = 4'd9;
  localparam logic [PhaseW-1:0] PhDone     = 4'd10;

  // Token status codes.
  localparam logic [StatusW-1:0] StOk      = 2'd0;
  localparam logic [StatusW-1:0] StInvalid = 2'd1;
  localparam logic [StatusW-1:0] StNoExp   = 2'd2;

  // Character codes.
  localparam logic [7:0] CharP     = 8'h70;
  localparam logic [7:0] CharE     = 8'h65;
  localparam logic [7:0] CharU     = 8'h75;
  localparam logic [7:0] CharLLow  = 8'h6C;
  localparam logic [7:0] CharLUp   = 8'h4C;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharF     = 8'h66;
  localparam logic [7:0] CharDot   = 8'h2E;

  // Classified character, as queued between the front and the back.
  typedef struct packed {
    logic start;
    logic radix_hex;
    logic dec;
    logic hex_alpha;
    logic u;
    logic l_lo;
    logic l_up;
    logic e;
    logic p;
    logic f;
    logic dot;
    logic sign;
  } char_class_t;

endpackage

FILE: rtl/cnls_if.sv
// Valid/ready channel interfaces for the scanner's input and result beats.
interface cnls_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       start_req;
  logic       radix_hex;
  logic       end_of_text;

  modport source (output valid, char_code, start_req, radix_hex, end_of_text,
                  input ready);
  modport sink (input valid, char_code, start_req, radix_hex, end_of_text,
                output ready);
endinterface

interface cnls_out_if;
  logic                           valid;
  logic                           ready;
  logic                           taken;
  logic                           token_end;
  logic [cnls_pkg::StatusW-1:0]   status;

  modport source (output valid, taken, token_end, status, input ready);
  modport sink (input valid, taken, token_end, status, output ready);
endinterface

FILE: rtl/cnls_front.sv
// Front end: accepts input beats and classifies each character.
module cnls_front (
  cnls_in_if.sink                 in_i,
  input  logic                    full_i,
  output logic                    push_o,
  output cnls_pkg::char_class_t   class_o
);

  logic [7:0] c;
  logic [7:0] lc;

  // End of text reads as a zero byte, which matches no class.
  assign c  = in_i.end_of_text ? 8'h00 : in_i.char_code;
  assign lc = (c >= 8'h41 && c <= 8'h5A) ? (c + 8'h20) : c;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    class_o.start     = in_i.start_req;
    class_o.radix_hex = in_i.radix_hex;
    class_o.dec       = (c >= 8'h30) && (c <= 8'h39);
    class_o.hex_alpha = (lc >= 8'h61) && (lc <= cnls_pkg::CharF);
    class_o.u         = (lc == cnls_pkg::CharU);
    class_o.l_lo      = (c == cnls_pkg::CharLLow);
    class_o.l_up      = (c == cnls_pkg::CharLUp);
    class_o.e         = (lc == cnls_pkg::CharE);
    class_o.p         = (lc == cnls_pkg::CharP);
    class_o.f         = (lc == cnls_pkg::CharF);
    class_o.dot       = (c == cnls_pkg::CharDot);
    class_o.sign      = (c == cnls_pkg::CharPlus) || (c == cnls_pkg::CharMinus);
  end

endmodule

FILE: rtl/cnls_queue.sv
// Short queue of classified characters between the front and the back.
module cnls_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  cnls_pkg::char_class_t  push_data_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output logic                   not_empty_o,
  output cnls_pkg::char_class_t  pop_data_i_o
);

  localparam int unsigned Depth = cnls_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  cnls_pkg::char_class_t entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o       = (count_q == CntW'(Depth));
  assign not_empty_o  = (count_q != '0);
  assign pop_data_i_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/cnls_back.sv
// Back end: token state machine and registered result beat.
module cnls_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   avail_i,
  input  cnls_pkg::char_class_t  class_i,
  output logic                   pop_o,
  cnls_out_if.source             out_o
);

  logic [cnls_pkg::PhaseW-1:0]  phase_q, phase_d, ph;
  logic                         hex_q, hex_d, hex;
  logic                         seen_q, seen_d, seen;
  logic                         upper_q, upper_d, upper;
  logic                         out_valid_q;
  logic                         taken_q, taken_d;
  logic                         end_q, end_d;
  logic [cnls_pkg::StatusW-1:0] status_q, status_d;
  logic                         mant, is_l, exp_hit, l_same, fl;

  assign pop_o = avail_i && (!out_valid_q || out_o.ready);

  always_comb begin
    // A start beat discards any open token.
    ph    = class_i.start ? cnls_pkg::PhInt : phase_q;
    hex   = class_i.start ? class_i.radix_hex : hex_q;
    seen  = class_i.start ? 1'b0 : seen_q;
    upper = class_i.start ? 1'b0 : upper_q;

    mant    = hex ? (class_i.dec || class_i.hex_alpha) : class_i.dec;
    is_l    = class_i.l_lo || class_i.l_up;
    exp_hit = hex ? class_i.p : class_i.e;
    l_same  = upper ? class_i.l_up : class_i.l_lo;
    fl      = class_i.f || is_l;

    phase_d  = ph;
    hex_d    = hex;
    seen_d   = seen;
    upper_d  = upper;
    taken_d  = 1'b0;
    end_d    = 1'b0;
    status_d = cnls_pkg::StOk;

    unique case (ph)
      cnls_pkg::PhInt: begin
        if (mant) begin
          taken_d = 1'b1;
          seen_d  = 1'b1;
        end else if (class_i.u || is_l) begin
          if (!seen) begin
            end_d    = 1'b1;
            status_d = cnls_pkg::StInvalid;
          end else if (class_i.u) begin
            taken_d = 1'b1;
            phase_d = cnls_pkg::PhU;
          end else begin
            taken_d = 1'b1;
            upper_d = class_i.l_up;
            phase_d = cnls_pkg::PhL;
          end
        end else if (exp_hit) begin
          if (seen) begin
            taken_d = 1'b1;
            phase_d = cnls_pkg::PhExpSign;
          end else begin
            end_d    = 1'b1;
            status_d = cnls_pkg::StInvalid;
          end
        end else if (class_i.dot) begin
          taken_d = 1'b1;
          phase_d = cnls_pkg::PhFrac;
        end else begin
          end_d = 1'b1;
        end
      end
      cnls_pkg::PhFrac: begin
        if (mant) begin
          taken_d = 1'b1;
          seen_d  = 1'b1;
        end else if (!seen) begin
          end_d    = 1'b1;
          status_d = cnls_pkg::StInvalid;
        end else if (exp_hit) begin
          taken_d = 1'b1;
          phase_d = cnls_pkg::PhExpSign;
        end else if (hex) begin
          // A hexadecimal fraction needs its exponent.
          end_d    = 1'b1;
          status_d = cnls_pkg::StInvalid;
        end else if (fl) begin
          taken_d = 1'b1;
          phase_d = cnls_pkg::PhDone;
        end else begin
          end_d = 1'b1;
        end
      end
      cnls_pkg::PhExpSign: begin
        if (class_i.sign) begin
          taken_d = 1'b1;
          phase_d = cnls_pkg::PhExpFirst;
        end else if (class_i.dec) begin
          taken_d = 1'b1;
          phase_d = cnls_pkg::PhExpDig;
        end else begin
          end_d    = 1'b1;
          status_d = cnls_pkg::StNoExp;
        end
      end
      cnls_pkg::PhExpFirst: begin
        if (class_i.dec) begin
          taken_d = 1'b1;
          phase_d = cnls_pkg::PhExpDig;
        end else begin
          end_d    = 1'b1;
          status_d = cnls_pkg::StNoExp;
        end
      end
      cnls_pkg::PhExpDig: begin
        if (class_i.dec) begin
          taken_d = 1'b1;
        end else if (fl) begin
          taken_d = 1'b1;
          phase_d = cnls_pkg::PhDone;
        end else begin
          end_d = 1'b1;
        end
      end
      cnls_pkg::PhU: begin
        if (is_l) begin
          taken_d = 1'b1;
          upper_d = class_i.l_up;
          phase_d = cnls_pkg::PhUl;
        end else begin
          end_d = 1'b1;
        end
      end
      cnls_pkg::PhUl: begin
        if (l_same) begin
          taken_d = 1'b1;
          phase_d = cnls_pkg::PhDone;
        end else begin
          end_d = 1'b1;
        end
      end
      cnls_pkg::PhL: begin
        if (l_same) begin
          taken_d = 1'b1;
          phase_d = cnls_pkg::PhLl;
        end else if (class_i.u) begin
          taken_d = 1'b1;
          phase_d = cnls_pkg::PhDone;
        end else begin
          end_d = 1'b1;
        end
      end
      cnls_pkg::PhLl: begin
        if (class_i.u) begin
          taken_d = 1'b1;
          phase_d = cnls_pkg::PhDone;
        end else begin
          end_d = 1'b1;
        end
      end
      cnls_pkg::PhDone: begin
        end_d = 1'b1;
      end
      default: begin
        phase_d = cnls_pkg::PhIdle;
      end
    endcase

    if (end_d) begin
      phase_d = cnls_pkg::PhIdle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= cnls_pkg::PhIdle;
      hex_q       <= 1'b0;
      seen_q      <= 1'b0;
      upper_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q <= phase_d;
        hex_q   <= hex_d;
        seen_q  <= seen_d;
        upper_q <= upper_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      taken_q  <= taken_d;
      end_q    <= end_d;
      status_q <= status_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.taken     = taken_q;
  assign out_o.token_end = end_q;
  assign out_o.status    = status_q;

endmodule

FILE: rtl/c_number_literal_scanner.sv
// Top level of the C numeric literal scanner.
//
// The block judges a C numeric literal one character per beat. Each beat on
// in_i carries a character byte with its start, radix and end-of-text flags;
// each beat on out_o carries one result: whether the character was taken
// into the number, whether the token ended just before it, and the status
// with which it ended. Both channels are valid/ready, a beat moving on a
// rising edge where both are high. Exactly one result beat leaves for each
// input beat, in order.
//
// A result is shown on out_o once its character has passed through the queue of
// classified characters and the state machine has loaded its output register.
// With the receiver ready, one beat is taken and one delivered in every cycle.
// When the receiver stalls, the output register holds its beat, the two-entry
// queue fills, and in_i.ready falls once it is full.
//
// Reset clears the token state to idle, empties the queue and drops
// out_o.valid; in_i.ready is high in the first cycle after reset.
module c_number_literal_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  cnls_in_if.sink     in_i,
  cnls_out_if.source  out_o
);

  logic                  push;
  logic                  full;
  logic                  pop;
  logic                  not_empty;
  cnls_pkg::char_class_t push_class;
  cnls_pkg::char_class_t pop_class;

  // The front only classifies the byte; all token state lives in the back,
  // so a character can be classified before the previous one is judged.
  cnls_front u_front (
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .class_o (push_class)
  );

  // The queue lets the front keep accepting while the back waits on a
  // stalled receiver.
  cnls_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_class),
    .full_o       (full),
    .pop_i        (pop),
    .not_empty_o  (not_empty),
    .pop_data_i_o (pop_class)
  );

  // The back advances the token state once per popped character and loads
  // the result into its output register.
  cnls_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (not_empty),
    .class_i (pop_class),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

FILE: rtl/cnls_checker.sv
// Port-level checks of the scanner, bound to its top level.
module cnls_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          out_taken_i,
  input logic                          out_token_end_i,
  input logic [cnls_pkg::StatusW-1:0]  out_status_i
);

  // A character that is taken cannot also close the token before it.
  a_taken_not_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(out_taken_i && out_token_end_i))
    else $error("result both takes the character and ends the token");

  // A non-zero status only accompanies the end of a token.
  a_status_needs_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (out_status_i != cnls_pkg::StOk)) |-> out_token_end_i)
    else $error("status reported without a token end");

  // Only the three defined status codes are ever shown.
  a_status_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((out_status_i == cnls_pkg::StOk) ||
                     (out_status_i == cnls_pkg::StInvalid) ||
                     (out_status_i == cnls_pkg::StNoExp)))
    else $error("undefined status code");

  // A stalled result beat stays put.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_taken_i) && $stable(out_token_end_i) &&
       $stable(out_status_i)))
    else $error("stalled result beat changed");

endmodule

bind c_number_literal_scanner cnls_checker u_cnls_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_taken_i     (out_o.taken),
  .out_token_end_i (out_o.token_end),
  .out_status_i    (out_o.status)
);

FILE: bench/tb_c_number_literal_scanner.sv
// Self-checking testbench for the C numeric literal scanner.
`timescale 1ns / 100ps

module tb_c_number_literal_scanner;

  // One input beat as the sender sees it, and the verdict that comes back for it.
  typedef struct packed {
    logic [7:0] char_code;
    logic       start_req;
    logic       radix_hex;
    logic       end_of_text;
  } char_beat_t;

  typedef struct packed {
    logic                         taken;
    logic                         token_end;
    logic [cnls_pkg::StatusW-1:0] status;
  } verdict_t;

  // A row of the directed table. Where fixed is set, the verdict is typed in by hand;
  // otherwise the literal lexer below supplies it.
  typedef struct packed {
    char_beat_t beat;
    logic       fixed;
    verdict_t   want;
  } plan_row_t;

  // The integer suffix spellings that the random literals draw from.
  typedef enum int {
    SfxU, SfxL, SfxLl, SfxUl, SfxUll, SfxLu, SfxLlu
  } int_suffix_e;

  localparam int TargetBeats  = 1750;
  localparam int HoldCycles   = 60;
  localparam int StallLimit   = 2000;
  localparam int SettleCycles = 8;

  // Idling profiles, in percent: none, sender only, receiver only, both.
  localparam int SendIdlePct [4] = '{0, 50, 0, 27};
  localparam int StallPct    [4] = '{0, 0, 50, 27};

  localparam logic [7:0] CharNul  = 8'h00;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharLowA = 8'h61;

  localparam verdict_t VerdictIdle       = '{1'b0, 1'b0, cnls_pkg::StOk};
  localparam verdict_t VerdictTaken      = '{1'b1, 1'b0, cnls_pkg::StOk};
  localparam verdict_t VerdictEndOk      = '{1'b0, 1'b1, cnls_pkg::StOk};
  localparam verdict_t VerdictEndInvalid = '{1'b0, 1'b1, cnls_pkg::StInvalid};
  localparam verdict_t VerdictEndNoExp   = '{1'b0, 1'b1, cnls_pkg::StNoExp};

  // The directed part: the quiet case before any token, a full decimal float with a
  // signed exponent and float suffix, the complete-token ending, a hex fraction that
  // lacks its exponent, an exponent with no digits before it, an integer suffix
  // with a matched pair of capital L's, a start that cuts into a complete token,
  // end of text in the middle of an exponent, and an empty token.
  localparam plan_row_t DirectedPlan [24] = '{
    '{'{"x",   1'b0, 1'b0, 1'b0}, 1'b1, VerdictIdle},
    '{'{8'hFF, 1'b0, 1'b1, 1'b1}, 1'b1, VerdictIdle},
    '{'{"1",   1'b1, 1'b0, 1'b0}, 1'b1, VerdictTaken},
    '{'{"2",   1'b0, 1'b0, 1'b0}, 1'b0, VerdictIdle},
    '{'{".",   1'b0, 1'b0, 1'b0}, 1'b0, VerdictIdle},
    '{'{"5",   1'b0, 1'b1, 1'b0}, 1'b0, VerdictIdle},
    '{'{"E",   1'b0, 1'b0, 1'b0}, 1'b0, VerdictIdle},
    '{'{"-",   1'b0, 1'b0, 1'b0}, 1'b0, VerdictIdle},
    '{'{"9",   1'b0, 1'b0, 1'b0}, 1'b0, VerdictIdle},
    '{'{"f",   1'b0, 1'b0, 1'b0}, 1'b0, VerdictIdle},
    '{'{"x",   1'b0, 1'b0, 1'b0}, 1'b1, VerdictEndOk},
    '{'{"A",   1'b1, 1'b1, 1'b0}, 1'b1, VerdictTaken},
    '{'{".",   1'b0, 1'b0, 1'b0}, 1'b0, VerdictIdle},
    '{'{"f",   1'b0, 1'b0, 1'b0}, 1'b0, VerdictIdle},
    '{'{";",   1'b0, 1'b0, 1'b0}, 1'b1, VerdictEndInvalid},
    '{'{"p",   1'b1, 1'b1, 1'b0}, 1'b1, VerdictEndInvalid},
    '{'{"7",   1'b1, 1'b0, 1'b0}, 1'b0, VerdictIdle},
    '{'{"u",   1'b0, 1'b0, 1'b0}, 1'b0, VerdictIdle},
    '{'{"L",   1'b0, 1'b0, 1'b0}, 1'b0, VerdictIdle},
    '{'{"L",   1'b0, 1'b0, 1'b0}, 1'b0, VerdictIdle},
    '{'{"3",   1'b1, 1'b0, 1'b0}, 1'b1, VerdictTaken},
    '{'{"e",   1'b0, 1'b0, 1'b0}, 1'b0, VerdictIdle},
    '{'{8'hFF, 1'b0, 1'b0, 1'b1}, 1'b1, VerdictEndNoExp},
    '{'{8'hFF, 1'b1, 1'b0, 1'b0}, 1'b1, VerdictEndOk}
  };

  logic clk = 1'b0;
  logic rst_n;

  cnls_in_if  in_ch ();
  cnls_out_if out_ch ();

  c_number_literal_scanner DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #2 clk = ~clk;

  // Lexer state mirrored by the testbench, advanced once per accepted input beat.
  logic [cnls_pkg::PhaseW-1:0] lex_phase;
  logic                        lex_hex;
  logic                        lex_digit_seen;
  logic                        lex_long_upper;

  verdict_t verdicts_due [$];

  int send_idle_pct;
  int stall_pct;
  bit hold_off_req;
  int beats_sent;
  int judged_beats;
  int results_checked;
  int ends_ok, ends_invalid, ends_no_exp;
  int failures;
  int quiet_cycles;

  function automatic logic is_decimal_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_hex_digit(logic [7:0] c);
    return is_decimal_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  // Judges one character against the open token and moves the lexer state on.
  function automatic verdict_t judge_char(char_beat_t b);
    logic [7:0]                   c;
    logic [7:0]                   lc;
    logic [7:0]                   exp_ch;
    logic [cnls_pkg::PhaseW-1:0]  ph;
    logic                         take;
    logic                         fin;
    logic                         mant;
    logic [cnls_pkg::StatusW-1:0] st;
    verdict_t                     v;
    c    = b.end_of_text ? CharNul : b.char_code;
    lc   = to_lower(c);
    ph   = lex_phase;
    take = 1'b0;
    fin  = 1'b0;
    st   = cnls_pkg::StOk;
    if (b.start_req) begin
      ph             = cnls_pkg::PhInt;
      lex_hex        = b.radix_hex;
      lex_digit_seen = 1'b0;
      lex_long_upper = 1'b0;
    end
    exp_ch = lex_hex ? cnls_pkg::CharP : cnls_pkg::CharE;
    mant   = lex_hex ? is_hex_digit(c) : is_decimal_digit(c);
    case (ph)
      cnls_pkg::PhInt: begin
        if (mant) begin
          take = 1'b1;
          lex_digit_seen = 1'b1;
        end else if (lc == cnls_pkg::CharU || lc == cnls_pkg::CharLLow) begin
          if (!lex_digit_seen) begin
            fin = 1'b1;
            st  = cnls_pkg::StInvalid;
          end else if (lc == cnls_pkg::CharU) begin
            take = 1'b1;
            ph   = cnls_pkg::PhU;
          end else begin
            take = 1'b1;
            lex_long_upper = (c == cnls_pkg::CharLUp);
            ph   = cnls_pkg::PhL;
          end
        end else if (lc == exp_ch) begin
          if (lex_digit_seen) begin
            take = 1'b1;
            ph   = cnls_pkg::PhExpSign;
          end else begin
            fin = 1'b1;
            st  = cnls_pkg::StInvalid;
          end
        end else if (c == cnls_pkg::CharDot) begin
          take = 1'b1;
          ph   = cnls_pkg::PhFrac;
        end else begin
          fin = 1'b1;
        end
      end
      cnls_pkg::PhFrac: begin
        if (mant) begin
          take = 1'b1;
          lex_digit_seen = 1'b1;
        end else if (!lex_digit_seen) begin
          fin = 1'b1;
          st  = cnls_pkg::StInvalid;
        end else if (lc == exp_ch) begin
          take = 1'b1;
          ph   = cnls_pkg::PhExpSign;
        end else if (lex_hex) begin
          fin = 1'b1;
          st  = cnls_pkg::StInvalid;
        end else if (lc == cnls_pkg::CharF || lc == cnls_pkg::CharLLow) begin
          take = 1'b1;
          ph   = cnls_pkg::PhDone;
        end else begin
          fin = 1'b1;
        end
      end
      cnls_pkg::PhExpSign: begin
        if (c == cnls_pkg::CharPlus || c == cnls_pkg::CharMinus) begin
          take = 1'b1;
          ph   = cnls_pkg::PhExpFirst;
        end else if (is_decimal_digit(c)) begin
          take = 1'b1;
          ph   = cnls_pkg::PhExpDig;
        end else begin
          fin = 1'b1;
          st  = cnls_pkg::StNoExp;
        end
      end
      cnls_pkg::PhExpFirst: begin
        if (is_decimal_digit(c)) begin
          take = 1'b1;
          ph   = cnls_pkg::PhExpDig;
        end else begin
          fin = 1'b1;
          st  = cnls_pkg::StNoExp;
        end
      end
      cnls_pkg::PhExpDig: begin
        if (is_decimal_digit(c)) begin
          take = 1'b1;
        end else if (lc == cnls_pkg::CharF || lc == cnls_pkg::CharLLow) begin
          take = 1'b1;
          ph   = cnls_pkg::PhDone;
        end else begin
          fin = 1'b1;
        end
      end
      cnls_pkg::PhU: begin
        if (lc == cnls_pkg::CharLLow) begin
          take = 1'b1;
          lex_long_upper = (c == cnls_pkg::CharLUp);
          ph   = cnls_pkg::PhUl;
        end else begin
          fin = 1'b1;
        end
      end
      cnls_pkg::PhUl: begin
        if (c == (lex_long_upper ? cnls_pkg::CharLUp : cnls_pkg::CharLLow)) begin
          take = 1'b1;
          ph   = cnls_pkg::PhDone;
        end else begin
          fin = 1'b1;
        end
      end
      cnls_pkg::PhL: begin
        if (c == (lex_long_upper ? cnls_pkg::CharLUp : cnls_pkg::CharLLow)) begin
          take = 1'b1;
          ph   = cnls_pkg::PhLl;
        end else if (lc == cnls_pkg::CharU) begin
          take = 1'b1;
          ph   = cnls_pkg::PhDone;
        end else begin
          fin = 1'b1;
        end
      end
      cnls_pkg::PhLl: begin
        if (lc == cnls_pkg::CharU) begin
          take = 1'b1;
          ph   = cnls_pkg::PhDone;
        end else begin
          fin = 1'b1;
        end
      end
      cnls_pkg::PhDone: begin
        fin = 1'b1;
      end
      default: begin
        ph = cnls_pkg::PhIdle;
      end
    endcase
    if (fin) begin
      ph = cnls_pkg::PhIdle;
    end
    lex_phase   = ph;
    v.taken     = take;
    v.token_end = fin;
    v.status    = fin ? st : cnls_pkg::StOk;
    return v;
  endfunction

  // Offers one beat, with a random idle gap in front of it, and waits until the
  // block accepts it. Entered and left just after a falling edge, so that valid
  // gets exactly one assignment per time step.
  task automatic send_beat(char_beat_t b, logic fixed, verdict_t want);
    verdict_t v;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.char_code   <= b.char_code;
    in_ch.start_req   <= b.start_req;
    in_ch.radix_hex   <= b.radix_hex;
    in_ch.end_of_text <= b.end_of_text;
    do @(posedge clk); while (!in_ch.ready);
    v = judge_char(b);
    verdicts_due.push_back(fixed ? want : v);
    beats_sent++;
    if (v.taken || v.token_end) begin
      judged_beats++;
    end
    @(negedge clk);
  endtask

  function automatic logic [7:0] random_case(logic [7:0] c);
    return $urandom_range(1) ? (c & 8'hDF) : c;
  endfunction

  function automatic char_beat_t plain_char(logic [7:0] c);
    char_beat_t b;
    b.char_code   = c;
    b.start_req   = 1'b0;
    b.radix_hex   = 1'($urandom_range(1));
    b.end_of_text = 1'b0;
    return b;
  endfunction

  function automatic logic [7:0] random_digit(logic hex);
    int k;
    k = hex ? $urandom_range(15) : $urandom_range(9);
    return (k < 10) ? CharZero + 8'(k) : random_case(CharLowA + 8'(k - 10));
  endfunction

  // A float suffix letter, f or l, in either case.
  function automatic logic [7:0] float_suffix();
    return $urandom_range(1) ? random_case(cnls_pkg::CharF)
                             : random_case(cnls_pkg::CharLLow);
  endfunction

  // Builds one mostly well-formed literal with random content, now and then with a
  // corrupted character, and sends it followed by a terminator, end of text, or
  // nothing at all so that the next start cuts in.
  task automatic send_literal();
    char_beat_t   seq [$];
    char_beat_t   b;
    logic         hex;
    logic [7:0]   l_first;
    logic [7:0]   l_second;
    logic [7:0]   u_ch;
    int_suffix_e  sfx;
    int           k;
    hex = 1'($urandom_range(1));
    repeat ($urandom_range(4)) seq.push_back(plain_char(random_digit(hex)));
    if ($urandom_range(2) == 0) begin
      seq.push_back(plain_char(cnls_pkg::CharDot));
      repeat ($urandom_range(3)) seq.push_back(plain_char(random_digit(hex)));
    end
    k = $urandom_range(9);
    if (k < 4) begin
      // The exponent letter of the other radix turns up now and then.
      seq.push_back(plain_char(random_case((hex ^ (k == 0)) ? cnls_pkg::CharP
                                                             : cnls_pkg::CharE)));
      if ($urandom_range(1)) begin
        seq.push_back(plain_char($urandom_range(1) ? cnls_pkg::CharPlus
                                                   : cnls_pkg::CharMinus));
      end
      repeat (($urandom_range(5) == 0) ? 0 : $urandom_range(1, 3)) begin
        seq.push_back(plain_char(CharZero + 8'($urandom_range(9))));
      end
      if ($urandom_range(1)) begin
        seq.push_back(plain_char(float_suffix()));
      end
    end else if (k < 7) begin
      u_ch     = random_case(cnls_pkg::CharU);
      l_first  = random_case(cnls_pkg::CharLLow);
      l_second = ($urandom_range(6) == 0) ? (l_first ^ 8'h20) : l_first;
      sfx      = int_suffix_e'($urandom_range(6));
      case (sfx)
        SfxU:   seq.push_back(plain_char(u_ch));
        SfxL:   seq.push_back(plain_char(l_first));
        SfxLl:  begin
          seq.push_back(plain_char(l_first));
          seq.push_back(plain_char(l_second));
        end
        SfxUl:  begin
          seq.push_back(plain_char(u_ch));
          seq.push_back(plain_char(l_first));
        end
        SfxUll: begin
          seq.push_back(plain_char(u_ch));
          seq.push_back(plain_char(l_first));
          seq.push_back(plain_char(l_second));
        end
        SfxLu:  begin
          seq.push_back(plain_char(l_first));
          seq.push_back(plain_char(u_ch));
        end
        default: begin
          seq.push_back(plain_char(l_first));
          seq.push_back(plain_char(l_second));
          seq.push_back(plain_char(u_ch));
        end
      endcase
    end else if (k == 7) begin
      seq.push_back(plain_char(float_suffix()));
    end
    if (seq.size() == 0) begin
      seq.push_back(plain_char(8'($urandom_range(255))));
    end
    if ($urandom_range(9) == 0) begin
      seq[$urandom_range(seq.size() - 1)].char_code = 8'($urandom_range(255));
    end
    seq[0].start_req = 1'b1;
    seq[0].radix_hex = hex;
    k = $urandom_range(9);
    if (k < 5) begin
      seq.push_back(plain_char(8'($urandom_range(255))));
    end else if (k < 7) begin
      b = plain_char(8'($urandom_range(255)));
      b.end_of_text = 1'b1;
      seq.push_back(b);
    end
    foreach (seq[i]) send_beat(seq[i], 1'b0, VerdictIdle);
  endtask

  // A few beats of plain noise: random bytes with random flags.
  task automatic send_noise();
    char_beat_t b;
    repeat ($urandom_range(1, 3)) begin
      b.char_code   = 8'($urandom_range(255));
      b.start_req   = ($urandom_range(3) == 0);
      b.radix_hex   = 1'($urandom_range(1));
      b.end_of_text = ($urandom_range(9) == 0);
      send_beat(b, 1'b0, VerdictIdle);
    end
  endtask

  // Receiver side. ready changes on the falling edge; on request it holds off for a
  // long stretch, counted here, so that the block's queue fills and in_i stalls.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Result checker: each delivered beat is compared with the oldest expected verdict.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (verdicts_due.size() == 0) begin
        failures++;
        $display("%0t: unexpected result beat, actual taken %0b end %0b status %0d",
                 $time, out_ch.taken, out_ch.token_end, out_ch.status);
      end else begin
        want = verdicts_due.pop_front();
        results_checked++;
        if (out_ch.taken !== want.taken) begin
          failures++;
          $display("%0t: taken mismatch, expected %0b, actual %0b",
                   $time, want.taken, out_ch.taken);
        end
        if (out_ch.token_end !== want.token_end) begin
          failures++;
          $display("%0t: token_end mismatch, expected %0b, actual %0b",
                   $time, want.token_end, out_ch.token_end);
        end
        if (out_ch.status !== want.status) begin
          failures++;
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, out_ch.status);
        end
        if (want.token_end) begin
          case (want.status)
            cnls_pkg::StOk:      ends_ok++;
            cnls_pkg::StInvalid: ends_invalid++;
            default:             ends_no_exp++;
          endcase
        end
      end
    end
  end

  // Watchdog: ends the run once no beat has moved on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no beat moved for %0d cycles", $time, StallLimit);
        $display("c_number_literal_scanner test failed");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.char_code   = '0;
    in_ch.start_req   = 1'b0;
    in_ch.radix_hex   = 1'b0;
    in_ch.end_of_text = 1'b0;
    lex_phase         = cnls_pkg::PhIdle;
    lex_hex           = 1'b0;
    lex_digit_seen    = 1'b0;
    lex_long_upper    = 1'b0;
    send_idle_pct     = 0;
    stall_pct         = 0;
    hold_off_req      = 1'b0;
    beats_sent        = 0;
    judged_beats      = 0;
    results_checked   = 0;
    ends_ok           = 0;
    ends_invalid      = 0;
    ends_no_exp       = 0;
    failures          = 0;

    // Reset is asserted at the start and released on a falling edge.
    rst_n = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed table, walked with both sides running freely.
    foreach (DirectedPlan[i]) begin
      send_beat(DirectedPlan[i].beat, DirectedPlan[i].fixed, DirectedPlan[i].want);
    end

    // Random literals across the four idling profiles. After the first profile the
    // receiver is held off while the sender keeps offering, to fill the block up.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = SendIdlePct[p];
      stall_pct     = StallPct[p];
      while (beats_sent < TargetBeats * (p + 1) / 4) begin
        if ($urandom_range(7) == 0) begin
          send_noise();
        end else begin
          send_literal();
        end
      end
      if (p == 0) begin
        hold_off_req = 1'b1;
        repeat (10) send_literal();
      end
    end
    in_ch.valid <= 1'b0;

    // Let every outstanding result come home, then watch a little longer for strays.
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("Run covered %0d input beats (%0d inside tokens) and %0d checked results,",
             beats_sent, judged_beats, results_checked);
    $display("with tokens ending %0d ok, %0d invalid, %0d missing an exponent.",
             ends_ok, ends_invalid, ends_no_exp);
    if (failures == 0) begin
      $display("c_number_literal_scanner test passed");
    end else begin
      $display("c_number_literal_scanner test failed");
    end
    $finish;
  end

endmodule
